### design/x86ea_pkg.sv
`timescale 1ns / 1ps

package x86ea_pkg;

    typedef enum logic [1:0] {
        ST_ADDR   = 2'd0,
        ST_WRITE  = 2'd1,
        ST_REG_OP = 2'd2
    } t_status;

    localparam logic       FUNC_WRITE = 1'b0;
    localparam logic       FUNC_EA    = 1'b1;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_REG    = 2'd3;

    localparam logic [2:0] SEG_ES = 3'd0;
    localparam logic [2:0] SEG_SS = 3'd2;
    localparam logic [2:0] SEG_DS = 3'd3;
    localparam logic [2:0] SEG_GS = 3'd5;

    localparam logic [2:0] GR_EBX = 3'd3;
    localparam logic [2:0] GR_ESP = 3'd4;
    localparam logic [2:0] GR_EBP = 3'd5;
    localparam logic [2:0] GR_ESI = 3'd6;
    localparam logic [2:0] GR_EDI = 3'd7;

    localparam logic [2:0] RM_SIB    = 3'd4;
    localparam logic [2:0] RM_DISP32 = 3'd5;
    localparam logic [2:0] RM_DIRECT = 3'd6;

    localparam logic [3:0] IDX_SEG_FIRST = 4'd8;
    localparam logic [3:0] IDX_SEG_LAST  = 4'd13;

    localparam int NUM_GPR = 8;
    localparam int NUM_SEG = 6;

    typedef struct packed {
        logic        func;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic        addr32;
        logic [1:0]  mod_field;
        logic [2:0]  rm_field;
        logic [7:0]  sib_byte;
        logic signed [31:0] displacement;
        logic [2:0]  seg_override;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [2:0]  segment_index;
        logic [15:0] segment_value;
        logic [31:0] offset;
    } t_rsp;

endpackage

### design/x86ea_if.sv
`timescale 1ns / 1ps

interface x86ea_req_if;
    import x86ea_pkg::*;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface x86ea_rsp_if;
    import x86ea_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/x86_modrm_effective_address.sv
`timescale 1ns / 1ps

// x86 ModR/M + SIB address generation. Takes one beat per cycle while the
// output is not stalled and returns one result beat per request, through one
// input register and then a single pass of operand select, a three-input
// 32-bit add and segment select into the result register.
// Register-write beats update the shadow register file as they leave the
// input register, so a following address beat already sees the new value.
// Backpressure from the output stalls both stages; throughput is one beat per
// cycle. Results: status 0 address, 1 register written, 2 register operand
// (mod 3); the latter two carry zero segment and offset.

module x86_modrm_effective_address
    import x86ea_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    x86ea_req_if.sink          i_req,
    x86ea_rsp_if.source        o_rsp
);

    t_req        r_req;
    logic        r_req_vld;
    t_rsp        r_rsp;
    logic        r_rsp_vld;
    logic [31:0] r_gpr [NUM_GPR];
    logic [15:0] r_seg [NUM_SEG];

    logic        advance;
    t_rsp        n_rsp;

    assign advance     = r_req_vld && (!r_rsp_vld || o_rsp.ready);
    assign i_req.ready = !r_req_vld || advance;
    assign o_rsp.valid = r_rsp_vld;
    assign o_rsp.data  = r_rsp;

    always_comb begin
        logic [31:0] term_a;
        logic [31:0] term_b;
        logic [31:0] term_d;
        logic [31:0] sum;
        logic [2:0]  seg;
        logic [2:0]  sib_idx;
        logic [2:0]  sib_base;
        logic [1:0]  sib_sc;
        logic        mod0;

        term_a   = '0;
        term_b   = '0;
        term_d   = '0;
        seg      = SEG_DS;
        sib_sc   = r_req.sib_byte[7:6];
        sib_idx  = r_req.sib_byte[5:3];
        sib_base = r_req.sib_byte[2:0];
        mod0     = (r_req.mod_field == MOD_NODISP);

        if (r_req.addr32) begin
            if (!mod0) begin
                term_d = r_req.displacement;
            end
            if (r_req.rm_field == RM_SIB) begin
                if (sib_idx != GR_ESP) begin
                    term_a = r_gpr[sib_idx] << sib_sc;
                end
                if (sib_base == GR_EBP && mod0) begin
                    term_d = r_req.displacement;
                end else begin
                    term_b = r_gpr[sib_base];
                    if (sib_base == GR_EBP || sib_base == GR_ESP) begin
                        seg = SEG_SS;
                    end
                end
            end else if (r_req.rm_field == RM_DISP32) begin
                if (mod0) begin
                    term_d = r_req.displacement;
                end else begin
                    term_b = r_gpr[GR_EBP];
                    seg    = SEG_SS;
                end
            end else begin
                term_b = r_gpr[r_req.rm_field];
            end
        end else begin
            if (!mod0 || r_req.rm_field == RM_DIRECT) begin
                term_d = {16'h0, r_req.displacement[15:0]};
            end
            case (r_req.rm_field)
                3'd0: begin
                    term_a = {16'h0, r_gpr[GR_EBX][15:0]};
                    term_b = {16'h0, r_gpr[GR_ESI][15:0]};
                end
                3'd1: begin
                    term_a = {16'h0, r_gpr[GR_EBX][15:0]};
                    term_b = {16'h0, r_gpr[GR_EDI][15:0]};
                end
                3'd2: begin
                    term_a = {16'h0, r_gpr[GR_EBP][15:0]};
                    term_b = {16'h0, r_gpr[GR_ESI][15:0]};
                    seg    = SEG_SS;
                end
                3'd3: begin
                    term_a = {16'h0, r_gpr[GR_EBP][15:0]};
                    term_b = {16'h0, r_gpr[GR_EDI][15:0]};
                    seg    = SEG_SS;
                end
                3'd4: term_b = {16'h0, r_gpr[GR_ESI][15:0]};
                3'd5: term_b = {16'h0, r_gpr[GR_EDI][15:0]};
                3'd6: begin
                    if (!mod0) begin
                        term_b = {16'h0, r_gpr[GR_EBP][15:0]};
                        seg    = SEG_SS;
                    end
                end
                default: term_b = {16'h0, r_gpr[GR_EBX][15:0]};
            endcase
        end

        sum = term_a + term_b + term_d;
        if (!r_req.addr32) begin
            sum = {16'h0, sum[15:0]};
        end

        if (r_req.seg_override <= SEG_GS) begin
            seg = r_req.seg_override;
        end
        if (seg > SEG_GS) begin
            seg = SEG_ES;
        end

        n_rsp = '{status: ST_ADDR, segment_index: '0, segment_value: '0, offset: '0};
        if (r_req.func == FUNC_WRITE) begin
            n_rsp.status = ST_WRITE;
        end else if (r_req.mod_field == MOD_REG) begin
            n_rsp.status = ST_REG_OP;
        end else begin
            n_rsp.segment_index = seg;
            n_rsp.segment_value = r_seg[seg];
            n_rsp.offset        = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
            for (int i = 0; i < NUM_GPR; i++) begin
                r_gpr[i] <= '0;
            end
            for (int i = 0; i < NUM_SEG; i++) begin
                r_seg[i] <= '0;
            end
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_req_vld <= 1'b1;
            end else if (advance) begin
                r_req_vld <= 1'b0;
            end

            if (advance) begin
                r_rsp_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_vld <= 1'b0;
            end

            if (advance && r_req.func == FUNC_WRITE) begin
                if (r_req.reg_index < IDX_SEG_FIRST) begin
                    r_gpr[r_req.reg_index[2:0]] <= r_req.reg_value;
                end else if (r_req.reg_index <= IDX_SEG_LAST) begin
                    // 8..13 map to segment 0..5 through the low bits
                    r_seg[r_req.reg_index[2:0]] <= r_req.reg_value[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
        if (advance) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

### design/x86ea_checker.sv
`timescale 1ns / 1ps

module x86ea_checker
    import x86ea_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic o_rsp_valid,
    input logic o_rsp_ready,
    input t_rsp o_rsp_data
);

    // result beat held while stalled
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid && $stable(o_rsp_data))
        else $error("result beat dropped or changed under stall");

    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_rsp_valid)
        else $error("result valid right after reset");

    a_non_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_data.status != ST_ADDR |->
            o_rsp_data.segment_index == '0 && o_rsp_data.segment_value == '0 &&
            o_rsp_data.offset == '0)
        else $error("non-address result carries address data");

    a_addr_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp_data.status != 2'd3 &&
            (o_rsp_data.status != ST_ADDR || o_rsp_data.segment_index <= SEG_GS))
        else $error("bad status or segment index");

endmodule

bind x86_modrm_effective_address x86ea_checker u_x86ea_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .o_rsp_valid (o_rsp.valid),
    .o_rsp_ready (o_rsp.ready),
    .o_rsp_data  (o_rsp.data)
);

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import x86ea_pkg::*;

    localparam logic [2:0] SEG_RSVD = 3'd6;
    localparam logic [2:0] SEG_NONE = 3'd7;

    // 16-bit r/m encodings
    localparam logic [2:0] RM16_BX_SI = 3'd0;
    localparam logic [2:0] RM16_BX_DI = 3'd1;
    localparam logic [2:0] RM16_BP_SI = 3'd2;
    localparam logic [2:0] RM16_BP_DI = 3'd3;
    localparam logic [2:0] RM16_SI    = 3'd4;
    localparam logic [2:0] RM16_DI    = 3'd5;
    localparam logic [2:0] RM16_BX    = 3'd7;

    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;

    localparam int N_RANDOM = 700;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    x86ea_req_if req_if ();
    x86ea_rsp_if rsp_if ();

    x86_modrm_effective_address u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow register file
    logic [31:0] shadow_gpr [NUM_GPR];
    logic [15:0] shadow_seg [NUM_SEG];

    t_req  addr_reqs [$];
    t_rsp  agu_expected [$];

    int unsigned n_fail = 0;
    int unsigned n_beats = 0;
    int unsigned n_writes = 0;
    int unsigned n_ea16 = 0;
    int unsigned n_ea32 = 0;
    int unsigned n_regop = 0;

    task automatic flag(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        n_fail++;
    endtask

    function automatic logic [31:0] lo16(logic [2:0] n);
        return {16'h0, shadow_gpr[n][15:0]};
    endfunction

    // Applies one accepted beat to the shadow state and returns its result.
    function automatic t_rsp agu_predict(t_req r);
        t_rsp        o;
        logic [31:0] a;
        logic [31:0] d;
        logic [2:0]  seg;
        logic [2:0]  idx;
        logic [2:0]  base;
        logic [1:0]  sc;
        o = '0;
        d = r.displacement;
        seg = SEG_DS;
        a = '0;
        if (r.func == FUNC_WRITE) begin
            if (r.reg_index < IDX_SEG_FIRST)
                shadow_gpr[r.reg_index[2:0]] = r.reg_value;
            else if (r.reg_index <= IDX_SEG_LAST)
                // 8..13 map to segment 0..5 through the low bits
                shadow_seg[r.reg_index[2:0]] = r.reg_value[15:0];
            o.status = ST_WRITE;
            n_writes++;
            return o;
        end
        if (r.mod_field == MOD_REG) begin
            o.status = ST_REG_OP;
            n_regop++;
            return o;
        end
        if (!r.addr32) begin
            n_ea16++;
            case (r.rm_field)
                RM16_BX_SI: a = lo16(GR_EBX) + lo16(GR_ESI);
                RM16_BX_DI: a = lo16(GR_EBX) + lo16(GR_EDI);
                RM16_BP_SI: begin
                    a = lo16(GR_EBP) + lo16(GR_ESI);
                    seg = SEG_SS;
                end
                RM16_BP_DI: begin
                    a = lo16(GR_EBP) + lo16(GR_EDI);
                    seg = SEG_SS;
                end
                RM16_SI: a = lo16(GR_ESI);
                RM16_DI: a = lo16(GR_EDI);
                RM_DIRECT: begin
                    if (r.mod_field == MOD_NODISP) begin
                        a = {16'h0, d[15:0]};
                    end else begin
                        a = lo16(GR_EBP);
                        seg = SEG_SS;
                    end
                end
                default: a = lo16(GR_EBX);
            endcase
            if (r.mod_field != MOD_NODISP)
                a = a + d;
            a = {16'h0, a[15:0]};
        end else begin
            n_ea32++;
            if (r.rm_field == RM_SIB) begin
                sc = r.sib_byte[7:6];
                idx = r.sib_byte[5:3];
                base = r.sib_byte[2:0];
                a = (idx == GR_ESP) ? 32'h0 : (shadow_gpr[idx] << sc);
                if (base == GR_EBP && r.mod_field == MOD_NODISP) begin
                    a = a + d;
                end else begin
                    a = a + shadow_gpr[base];
                    if (base == GR_EBP || base == GR_ESP)
                        seg = SEG_SS;
                end
            end else if (r.rm_field == RM_DISP32) begin
                if (r.mod_field == MOD_NODISP) begin
                    a = d;
                end else begin
                    a = shadow_gpr[GR_EBP];
                    seg = SEG_SS;
                end
            end else begin
                a = shadow_gpr[r.rm_field];
            end
            if (r.mod_field != MOD_NODISP)
                a = a + d;
        end
        if (r.seg_override <= SEG_GS)
            seg = r.seg_override;
        o.status = ST_ADDR;
        o.segment_index = seg;
        o.segment_value = shadow_seg[seg];
        o.offset = a;
        return o;
    endfunction

    function automatic t_req noise_req();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(t_req)-1:0];
    endfunction

    function automatic t_req mk_write(logic [3:0] idx, logic [31:0] val);
        t_req r;
        r = noise_req();
        r.func = FUNC_WRITE;
        r.reg_index = idx;
        r.reg_value = val;
        return r;
    endfunction

    function automatic t_req mk_ea(logic a32, logic [1:0] md, logic [2:0] rm,
                                   logic [7:0] sib, logic [31:0] disp, logic [2:0] ovr);
        t_req r;
        r = noise_req();
        r.func = FUNC_EA;
        r.addr32 = a32;
        r.mod_field = md;
        r.rm_field = rm;
        r.sib_byte = sib;
        r.displacement = disp;
        r.seg_override = ovr;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_disp();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 3))
            0: return {{24{v[7]}}, v[7:0]};
            1: return {{16{v[15]}}, v[15:0]};
            default: return v;
        endcase
    endfunction

    function automatic logic [2:0] pick_ovr();
        if ($urandom_range(0, 3) == 0)
            return SEG_NONE;
        return 3'($urandom_range(0, 7));
    endfunction

    // request driver
    int unsigned src_wait = 0;
    bit          src_quiet = 1'b0;

    always @(posedge i_clk) begin : drv
        t_rsp want;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                want = agu_predict(req_if.data);
                agu_expected.push_back(want);
            end
            if (!req_if.valid || req_if.ready) begin
                if (src_wait != 0) begin
                    src_wait--;
                    req_if.valid <= 1'b0;
                end else if (addr_reqs.size() != 0) begin
                    req_if.data <= addr_reqs.pop_front();
                    req_if.valid <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        src_quiet = ~src_quiet;
                    src_wait = src_quiet ? 0 : $urandom_range(0, 9);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    int unsigned snk_wait = 0;
    bit          snk_quiet = 1'b0;

    always @(posedge i_clk) begin : mon
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_beats++;
                got = rsp_if.data;
                if (agu_expected.size() == 0) begin
                    flag($sformatf("result beat with nothing expected, status %0d",
                                   got.status));
                end else begin
                    want = agu_expected.pop_front();
                    if (got.status !== want.status)
                        flag($sformatf("beat %0d status %0d, want %0d",
                                       n_beats, got.status, want.status));
                    if (got.segment_index !== want.segment_index)
                        flag($sformatf("beat %0d segment_index %0d, want %0d",
                                       n_beats, got.segment_index, want.segment_index));
                    if (got.segment_value !== want.segment_value)
                        flag($sformatf("beat %0d segment_value %h, want %h",
                                       n_beats, got.segment_value, want.segment_value));
                    if (got.offset !== want.offset)
                        flag($sformatf("beat %0d offset %h, want %h",
                                       n_beats, got.offset, want.offset));
                end
                if ($urandom_range(0, 49) == 0)
                    snk_quiet = ~snk_quiet;
                snk_wait = snk_quiet ? 0 : $urandom_range(0, 9);
            end
            if (snk_wait != 0) begin
                snk_wait--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int k;
        for (k = 0; k < NUM_GPR; k++)
            shadow_gpr[k] = '0;
        for (k = 0; k < NUM_SEG; k++)
            shadow_seg[k] = '0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;

        // directed
        addr_reqs.push_back(mk_write({1'b0, GR_EBX}, 32'hFFFF_FFFF));
        addr_reqs.push_back(mk_write({1'b0, GR_EBP}, 32'h8000_0001));
        addr_reqs.push_back(mk_write({1'b0, GR_ESI}, 32'h0000_FFFF));
        addr_reqs.push_back(mk_write({1'b0, GR_ESP}, 32'h1234_5678));
        addr_reqs.push_back(mk_write(IDX_SEG_FIRST + SEG_SS, 32'hABCD_FFFF));
        addr_reqs.push_back(mk_write(IDX_SEG_FIRST + SEG_DS, 32'h0000_1234));
        addr_reqs.push_back(mk_write(IDX_SEG_LAST + 4'd2, 32'hDEAD_BEEF));
        addr_reqs.push_back(mk_write(IDX_SEG_LAST + 4'd1, 32'hFFFF_FFFF));
        addr_reqs.push_back(mk_ea(1'b0, MOD_NODISP, RM_DIRECT, 8'h00, 32'hFFFF_8000,
                                  SEG_NONE));
        addr_reqs.push_back(mk_ea(1'b0, MOD_DISP32, RM_DIRECT, 8'hFF, 32'hFFFF_FFFF,
                                  SEG_NONE));
        addr_reqs.push_back(mk_ea(1'b0, MOD_DISP8, RM16_BX_SI, 8'h00, 32'h0000_007F,
                                  SEG_NONE));
        addr_reqs.push_back(mk_ea(1'b0, MOD_NODISP, RM16_BP_DI, 8'h00, $urandom(),
                                  SEG_NONE));
        addr_reqs.push_back(mk_ea(1'b1, MOD_NODISP, RM_SIB, {2'd3, GR_ESI, GR_EBP},
                                  32'h7FFF_FFFF, SEG_NONE));
        addr_reqs.push_back(mk_ea(1'b1, MOD_DISP8, RM_SIB, {2'd0, GR_ESP, GR_ESP},
                                  32'hFFFF_FF80, SEG_NONE));
        addr_reqs.push_back(mk_ea(1'b1, MOD_DISP32, RM_SIB, {2'd2, GR_EBX, GR_EBP},
                                  32'h8000_0000, SEG_NONE));
        addr_reqs.push_back(mk_ea(1'b1, MOD_NODISP, RM_DISP32, 8'h00, 32'hFFFF_FFFF,
                                  SEG_NONE));
        addr_reqs.push_back(mk_ea(1'b1, MOD_DISP32, RM_DISP32, 8'h00, 32'h0000_0001,
                                  SEG_NONE));
        addr_reqs.push_back(mk_ea(1'b1, MOD_NODISP, GR_EBX, 8'h00, $urandom(), SEG_NONE));
        addr_reqs.push_back(mk_ea(1'b1, MOD_REG, RM_SIB, 8'hFF, 32'hFFFF_FFFF, SEG_SS));
        addr_reqs.push_back(mk_ea(1'b0, MOD_REG, RM_DIRECT, 8'h00, 32'h0, SEG_NONE));
        addr_reqs.push_back(mk_ea(1'b0, MOD_DISP8, RM16_BP_SI, 8'h00, 32'h1, SEG_RSVD));
        addr_reqs.push_back(mk_ea(1'b1, MOD_DISP8, RM_DISP32, 8'h00, 32'h2, SEG_GS));
        addr_reqs.push_back(mk_ea(1'b0, MOD_NODISP, RM16_BX, 8'h00, 32'h0, SEG_ES));

        // random
        for (k = 0; k < N_RANDOM; k++) begin
            if ($urandom_range(0, 9) < 3)
                addr_reqs.push_back(mk_write(4'($urandom_range(0, 15)), pick_value()));
            else
                addr_reqs.push_back(mk_ea(1'($urandom_range(0, 1)),
                                          2'($urandom_range(0, 3)),
                                          3'($urandom_range(0, 7)),
                                          8'($urandom_range(0, 255)),
                                          pick_disp(), pick_ovr()));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        while (addr_reqs.size() != 0 || req_if.valid)
            @(posedge i_clk);
        for (k = 0; k < 500 && agu_expected.size() != 0; k++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (agu_expected.size() != 0)
            flag($sformatf("%0d results never arrived", agu_expected.size()));

        $display("run: %0d register writes, %0d 16-bit and %0d 32-bit addresses,",
                 n_writes, n_ea16, n_ea32);
        $display("     %0d register operands, %0d result beats checked, %0d mismatches",
                 n_regop, n_beats, n_fail);
        if (n_fail == 0) begin
            $display("x86_modrm_effective_address verification clean");
        end else begin
            $display("x86_modrm_effective_address verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("x86_modrm_effective_address verification failed");
        $finish;
    end

endmodule
